// File: rtl/core/assert_macros.svh
// Assertion macros used by the top level of the header parser.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rstn, ante, cons)
`define ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

// File: rtl/core/uihp_pkg.sv
// Package with the types, constants and helpers of the update image header parser.
package uihp_pkg;

    localparam int unsigned MAGIC_LEN     = 5;
    localparam int unsigned HDR_FIXED_LEN = 13;
    localparam int unsigned MIN_LEN       = 17;
    localparam int unsigned SIG_FIELD_LEN = 4;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_BOUNDS = 2'd1,
        ST_MAGIC  = 2'd2
    } status_t;

    // Header view after the current byte has been merged in.
    typedef struct packed {
        logic [31:0] pos;
        logic        magic_ok;
        logic [31:0] version;
        logic [31:0] payload;
        logic [31:0] sig_length;
    } hdr_view_t;

    typedef struct packed {
        status_t     status;
        logic [31:0] sec_version;
        logic [31:0] payload_length;
        logic [31:0] signature_offset;
        logic [31:0] signature_length;
    } hdr_result_t;

    function automatic logic [7:0] magic_byte(input logic [2:0] idx);
        logic [7:0] b;
        case (idx)
            3'd0:    b = 8'h50;
            3'd1:    b = 8'h45;
            3'd2:    b = 8'h4F;
            3'd3:    b = 8'h54;
            3'd4:    b = 8'h41;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    function automatic logic [31:0] put_le_byte(input logic [31:0] word,
                                                input logic [1:0]  lane,
                                                input logic [7:0]  b);
        logic [31:0] w;
        w = word;
        case (lane)
            2'd0:    w[7:0]   = b;
            2'd1:    w[15:8]  = b;
            2'd2:    w[23:16] = b;
            2'd3:    w[31:24] = b;
            default: w = word;
        endcase
        return w;
    endfunction

endpackage

// File: rtl/core/update_image_header_parser_top.sv
// Top level of the update image header parser: input register, capture, checks, result register.
//
// The parser takes one image byte per cycle while s_tready is high and gives one result request
// after the byte flagged by s_tlast. A byte is held in an input register, where it is merged into
// the header fields and checked, and the result is registered, so m_tvalid rises when the result
// register loads the check of the final byte. The sustained rate is one byte per clock, set by
// the capture stage; input is held back only while a finished result waits on m_tready and
// another final byte is pending. After each final byte the parser returns to its reset state
// for the next image. The byte counter saturates at 2^32 - 1.
`include "assert_macros.svh"
module update_image_header_parser_top
    import uihp_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] data_byte
    input  logic         s_tlast,   // last_byte
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,   // [31:0] sec_version, [63:32] payload_length,
                                    // [95:64] signature_offset, [127:96] signature_length
    output logic [1:0]   m_tuser    // [1:0] status
);

    logic        in_valid_reg, in_valid_next;
    logic [7:0]  in_data_reg;
    logic        in_last_reg;
    logic        out_valid_reg, out_valid_next;
    hdr_result_t out_reg;

    logic        s_accept;
    logic        advance;
    logic        out_load;
    hdr_view_t   view;
    hdr_result_t result;
    logic        offset_match;

    // A byte that is not final never waits on the result side.
    assign advance  = in_valid_reg && (!in_last_reg || !out_valid_reg || m_tready);
    assign out_load = advance && in_last_reg;
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    uihp_capture u_capture (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .data_byte (in_data_reg),
        .last_byte (in_last_reg),
        .view      (view)
    );

    uihp_check u_check (
        .view   (view),
        .result (result)
    );

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (out_load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_data_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        if (out_load) begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.status;
    assign m_tdata  = {out_reg.signature_length, out_reg.signature_offset,
                       out_reg.payload_length, out_reg.sec_version};

    assign offset_match = (m_tdata[95:64] == (m_tdata[63:32] + 32'(HDR_FIXED_LEN)));

    `ASSERT_IMPL(a_err_zero, aclk, aresetn, m_tvalid && (m_tuser != ST_OK), m_tdata == '0)
    `ASSERT_IMPL(a_ok_offset, aclk, aresetn, m_tvalid && (m_tuser == ST_OK), offset_match)
    `ASSERT_NEXT(a_res_src, aclk, aresetn, !out_valid_reg && !out_load, !out_valid_reg)

endmodule

// File: rtl/core/uihp_capture.sv
// Byte counter and field capture registers of the header parser.
module uihp_capture
    import uihp_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       advance,
    input  logic [7:0] data_byte,
    input  logic       last_byte,
    output hdr_view_t  view
);

    logic [31:0] count_reg, count_next;
    logic        magic_ok_reg, magic_ok_next;
    logic [31:0] version_reg, version_next;
    logic [31:0] payload_reg, payload_next;
    logic [31:0] sig_reg, sig_next;

    logic [32:0] sig_pos;
    logic [32:0] sig_diff;
    logic        in_sig;
    logic [1:0]  hdr_lane;
    logic        magic_match;

    assign sig_pos  = {1'b0, payload_reg} + 33'(HDR_FIXED_LEN);
    assign sig_diff = {1'b0, count_reg} - sig_pos;
    assign in_sig   = ({1'b0, count_reg} >= sig_pos) && (sig_diff < 33'(SIG_FIELD_LEN));
    // Version starts at byte five and payload length at byte nine: both lanes are pos - 1.
    assign hdr_lane = count_reg[1:0] - 2'd1;
    assign magic_match = (data_byte == magic_byte(count_reg[2:0]));

    always_comb begin
        view.pos        = count_reg;
        view.magic_ok   = magic_ok_reg;
        view.version    = version_reg;
        view.payload    = payload_reg;
        view.sig_length = sig_reg;
        if (count_reg < 32'(MAGIC_LEN)) begin
            view.magic_ok = magic_ok_reg & magic_match;
        end else if (count_reg < 32'd9) begin
            view.version = put_le_byte(version_reg, hdr_lane, data_byte);
        end else if (count_reg < 32'(HDR_FIXED_LEN)) begin
            view.payload = put_le_byte(payload_reg, hdr_lane, data_byte);
        end else if (in_sig) begin
            view.sig_length = put_le_byte(sig_reg, sig_diff[1:0], data_byte);
        end
    end

    always_comb begin
        count_next    = count_reg;
        magic_ok_next = magic_ok_reg;
        version_next  = version_reg;
        payload_next  = payload_reg;
        sig_next      = sig_reg;
        if (advance) begin
            if (last_byte) begin
                count_next    = '0;
                magic_ok_next = 1'b1;
                version_next  = '0;
                payload_next  = '0;
                sig_next      = '0;
            end else begin
                count_next    = (count_reg == '1) ? count_reg : count_reg + 32'd1;
                magic_ok_next = view.magic_ok;
                version_next  = view.version;
                payload_next  = view.payload;
                sig_next      = view.sig_length;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            magic_ok_reg <= 1'b1;
            version_reg  <= '0;
            payload_reg  <= '0;
            sig_reg      <= '0;
        end else begin
            count_reg    <= count_next;
            magic_ok_reg <= magic_ok_next;
            version_reg  <= version_next;
            payload_reg  <= payload_next;
            sig_reg      <= sig_next;
        end
    end

endmodule

// File: rtl/core/uihp_check.sv
// End-of-image layout checks and result formation of the header parser.
module uihp_check
    import uihp_pkg::*;
(
    input  hdr_view_t   view,
    output hdr_result_t result
);

    logic [32:0] img_len;
    logic [32:0] avail;
    logic [32:0] pay33;
    logic [32:0] remain;
    logic        too_short;
    logic        pay_over;
    logic        sig_missing;
    logic        sig_over;
    status_t     status;

    // The image length can reach 2^32 once the counter has saturated, hence 33 bits.
    assign img_len     = {1'b0, view.pos} + 33'd1;
    assign avail       = img_len - 33'(HDR_FIXED_LEN);
    assign pay33       = {1'b0, view.payload};
    assign remain      = avail - pay33;
    assign too_short   = img_len < 33'(MIN_LEN);
    assign pay_over    = pay33 > avail;
    assign sig_missing = remain < 33'(SIG_FIELD_LEN);
    assign sig_over    = {1'b0, view.sig_length} > (remain - 33'(SIG_FIELD_LEN));

    always_comb begin
        if (too_short) begin
            status = ST_BOUNDS;
        end else if (!view.magic_ok) begin
            status = ST_MAGIC;
        end else if (pay_over || sig_missing || sig_over) begin
            status = ST_BOUNDS;
        end else begin
            status = ST_OK;
        end
    end

    always_comb begin
        result.status = status;
        if (status == ST_OK) begin
            result.sec_version      = view.version;
            result.payload_length   = view.payload;
            result.signature_offset = view.payload + 32'(HDR_FIXED_LEN);
            result.signature_length = view.sig_length;
        end else begin
            result.sec_version      = '0;
            result.payload_length   = '0;
            result.signature_offset = '0;
            result.signature_length = '0;
        end
    end

endmodule
